### rtl/core/mse_pkg.sv
// Shared types, constants and the character lookup for the Morse timing encoder.
// No dependencies; every other file in rtl/core imports this package.
package mse_pkg;

  // Input word: one character and the look-ahead flag
  typedef struct packed {
    logic [7:0] char_code;
    logic       next_is_space;
  } mse_in_t;

  // Output word: one keying segment
  typedef struct packed {
    logic        tone_on;
    logic [2:0]  units;
    logic [10:0] duration_ms;
    logic        last;
  } mse_out_t;

  // Symbol pattern: len symbols, 1 = dash, first symbol at bit len-1
  typedef struct packed {
    logic [2:0] len;
    logic [5:0] bits;
  } mse_code_t;

  // Classified character handed from front to back
  typedef struct packed {
    logic       is_blank;
    mse_code_t  code;
    logic       next_is_space;
  } mse_rec_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic empty;
    logic full;
  } mse_qstat_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SYM,
    ST_GAP,
    ST_WORD,
    ST_LETTER
  } mse_state_t;

  // Segment lengths in dot units
  localparam logic [2:0] LEN_DOT    = 3'd1;
  localparam logic [2:0] LEN_DASH   = 3'd3;
  localparam logic [2:0] GAP_SYMBOL = 3'd1;
  localparam logic [2:0] GAP_LETTER = 3'd3;
  localparam logic [2:0] GAP_WORD   = 3'd7;

  // Character codes
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_EXCL  = 8'h21;
  localparam logic [7:0] CHAR_QUEST = 8'h3F;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_SEMI  = 8'h3B;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;

  // Config register index and reset value
  localparam logic       REG_DOT_MS   = 1'b0;
  localparam logic [7:0] DOT_MS_RESET = 8'd60;

  // Letter table, indexed by the low five bits of the code (A/a = 1)
  function automatic mse_code_t mse_letter(input logic [4:0] idx);
    mse_code_t r;
    r = '0;
    unique case (idx)
      5'd1:  r = '{3'd2, 6'h01};
      5'd2:  r = '{3'd4, 6'h08};
      5'd3:  r = '{3'd4, 6'h0A};
      5'd4:  r = '{3'd3, 6'h04};
      5'd5:  r = '{3'd1, 6'h00};
      5'd6:  r = '{3'd4, 6'h02};
      5'd7:  r = '{3'd3, 6'h06};
      5'd8:  r = '{3'd4, 6'h00};
      5'd9:  r = '{3'd2, 6'h00};
      5'd10: r = '{3'd4, 6'h07};
      5'd11: r = '{3'd3, 6'h05};
      5'd12: r = '{3'd4, 6'h04};
      5'd13: r = '{3'd2, 6'h03};
      5'd14: r = '{3'd2, 6'h02};
      5'd15: r = '{3'd3, 6'h07};
      5'd16: r = '{3'd4, 6'h06};
      5'd17: r = '{3'd4, 6'h0D};
      5'd18: r = '{3'd3, 6'h02};
      5'd19: r = '{3'd3, 6'h00};
      5'd20: r = '{3'd1, 6'h01};
      5'd21: r = '{3'd3, 6'h01};
      5'd22: r = '{3'd4, 6'h01};
      5'd23: r = '{3'd3, 6'h03};
      5'd24: r = '{3'd4, 6'h09};
      5'd25: r = '{3'd4, 6'h0B};
      5'd26: r = '{3'd4, 6'h0C};
      default: r = '0;
    endcase
    return r;
  endfunction

  // Digit table, five symbols each
  function automatic mse_code_t mse_digit(input logic [3:0] idx);
    mse_code_t r;
    r.len = 3'd5;
    unique case (idx)
      4'd0: r.bits = 6'd31;
      4'd1: r.bits = 6'd15;
      4'd2: r.bits = 6'd7;
      4'd3: r.bits = 6'd3;
      4'd4: r.bits = 6'd1;
      4'd5: r.bits = 6'd0;
      4'd6: r.bits = 6'd16;
      4'd7: r.bits = 6'd24;
      4'd8: r.bits = 6'd28;
      4'd9: r.bits = 6'd30;
      default: begin
        r.len  = 3'd0;
        r.bits = 6'd0;
      end
    endcase
    return r;
  endfunction

  // Full character lookup; unknown characters give an empty pattern
  function automatic mse_code_t mse_lookup(input logic [7:0] c);
    mse_code_t r;
    r = '0;
    if ((c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
        (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)) begin
      r = mse_letter(c[4:0]);
    end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
      r = mse_digit(c[3:0]);
    end else begin
      unique case (c)
        CHAR_EXCL:  r = '{3'd6, 6'd43};
        CHAR_QUEST: r = '{3'd6, 6'd12};
        CHAR_COMMA: r = '{3'd6, 6'd51};
        CHAR_DOT:   r = '{3'd6, 6'd21};
        CHAR_SEMI:  r = '{3'd6, 6'd42};
        CHAR_COLON: r = '{3'd6, 6'd56};
        default:    r = '0;
      endcase
    end
    return r;
  endfunction

endpackage

### rtl/core/morse_symbol_timing_encoder_core.sv
// Morse symbol timing encoder: one character in, its keying segments out.
// First segment path: the taken character passes the state register, then
// the output register. Segments leave one per cycle while the output slot is
// free or popped, plus an idle load step per character (back-end sequencer).
// Reset: dot_ms returns to 60, queue and output register are emptied.
module morse_symbol_timing_encoder_core import mse_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  // character input
  input  logic        push,
  output logic        full,
  input  mse_in_t     item,
  // segment output
  output logic        empty,
  input  logic        pop,
  output mse_out_t    result,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] dot_ms;
  mse_qstat_t qstat;
  logic       q_wr;
  logic       q_rd;
  mse_rec_t   q_wdata;
  mse_rec_t   q_rdata;

  // Config register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      dot_ms <= DOT_MS_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_DOT_MS) begin
      dot_ms <= pwdata[7:0];
    end
  end
  assign prdata = (paddr[2] == REG_DOT_MS) ? {24'd0, dot_ms} : 32'd0;

  mse_front u_front (
    .push    (push),
    .full    (full),
    .item    (item),
    .qstat   (qstat),
    .q_wr    (q_wr),
    .q_wdata (q_wdata)
  );

  mse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wdata (q_wdata),
    .rd    (q_rd),
    .rdata (q_rdata),
    .qstat (qstat)
  );

  mse_back u_back (
    .clk     (clk),
    .rst     (rst),
    .dot_ms  (dot_ms),
    .qstat   (qstat),
    .q_rdata (q_rdata),
    .q_rd    (q_rd),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

### rtl/core/mse_front.sv
// Front end: accepts characters and classifies them into symbol patterns.
// Depends on mse_pkg; feeds mse_queue.
module mse_front import mse_pkg::*; (
  input  logic       push,
  output logic       full,
  input  mse_in_t    item,
  input  mse_qstat_t qstat,
  output logic       q_wr,
  output mse_rec_t   q_wdata
);

  // Accept a word whenever the queue has room
  assign full = qstat.full;
  assign q_wr = push && !qstat.full;

  // Classify: space, known pattern, or empty pattern for unknown codes
  always_comb begin
    q_wdata.is_blank      = (item.char_code == CHAR_SPACE);
    q_wdata.code          = mse_lookup(item.char_code);
    q_wdata.next_is_space = item.next_is_space;
  end

endmodule

### rtl/core/mse_queue.sv
// Short queue of classified characters between front and back end.
// Depends on mse_pkg for the record and status types.
module mse_queue import mse_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr,
  input  mse_rec_t   wdata,
  input  logic       rd,
  output mse_rec_t   rdata,
  output mse_qstat_t qstat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mse_rec_t        mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign qstat.empty = (count == '0);
  assign qstat.full  = (count == CW'(DEPTH));
  assign rdata       = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/core/mse_back.sv
// Back end: steps through one character's segments, one per cycle while the
// output register is free or popped. Depends on mse_pkg; reads mse_queue.
module mse_back import mse_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] dot_ms,
  input  mse_qstat_t qstat,
  input  mse_rec_t   q_rdata,
  output logic       q_rd,
  output logic       empty,
  input  logic       pop,
  output mse_out_t   result
);

  mse_state_t state;
  mse_state_t state_next;
  logic [2:0] len;
  logic [5:0] bits;
  logic       next_space;
  logic [2:0] idx;
  logic       out_valid;
  mse_out_t   out_reg;

  logic       adv;
  logic       at_end;
  logic [2:0] sel;
  logic       seg_tone;
  logic [2:0] seg_units;
  logic       seg_last;

  // Output slot is free or being drained
  assign adv    = !out_valid || pop;
  assign q_rd   = (state == ST_IDLE) && !qstat.empty;
  assign at_end = (idx == len - 3'd1);
  assign sel    = len - 3'd1 - idx;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (!qstat.empty) begin
          if (q_rdata.is_blank) begin
            state_next = ST_WORD;
          end else if (q_rdata.code.len != 3'd0) begin
            state_next = ST_SYM;
          end else if (!q_rdata.next_is_space) begin
            state_next = ST_LETTER;
          end
        end
      end
      ST_SYM: begin
        if (adv) begin
          if (!at_end) begin
            state_next = ST_GAP;
          end else begin
            state_next = next_space ? ST_IDLE : ST_LETTER;
          end
        end
      end
      ST_GAP: begin
        if (adv) begin
          state_next = ST_SYM;
        end
      end
      ST_WORD: begin
        if (adv) begin
          state_next = next_space ? ST_IDLE : ST_LETTER;
        end
      end
      ST_LETTER: begin
        if (adv) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Segment for the current state
  always_comb begin
    seg_tone  = 1'b0;
    seg_units = GAP_SYMBOL;
    seg_last  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        seg_units = GAP_SYMBOL;
      end
      ST_SYM: begin
        seg_tone  = 1'b1;
        seg_units = bits[sel] ? LEN_DASH : LEN_DOT;
        seg_last  = at_end && next_space;
      end
      ST_GAP: begin
        seg_units = GAP_SYMBOL;
      end
      ST_WORD: begin
        seg_units = GAP_WORD;
        seg_last  = next_space;
      end
      ST_LETTER: begin
        seg_units = GAP_LETTER;
        seg_last  = 1'b1;
      end
      default: seg_units = GAP_SYMBOL;
    endcase
  end

  // Sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (adv) begin
        out_valid <= (state != ST_IDLE);
      end
    end
  end

  // Character context and symbol index
  always_ff @(posedge clk) begin
    if (q_rd) begin
      len        <= q_rdata.code.len;
      bits       <= q_rdata.code.bits;
      next_space <= q_rdata.next_is_space;
      idx        <= '0;
    end else if (state == ST_GAP && adv) begin
      idx <= idx + 3'd1;
    end
  end

  // Output word, duration scaled by the dot length
  always_ff @(posedge clk) begin
    if (adv && state != ST_IDLE) begin
      out_reg.tone_on     <= seg_tone;
      out_reg.units       <= seg_units;
      out_reg.duration_ms <= 11'(seg_units) * 11'(dot_ms);
      out_reg.last        <= seg_last;
    end
  end

  assign empty  = !out_valid;
  assign result = out_reg;

  // Tone segments are a dot or a dash
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_reg.tone_on) |->
      (out_reg.units == LEN_DOT || out_reg.units == LEN_DASH))
    else $error("tone segment with bad length");

  // Symbol index stays inside the pattern
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SYM || state == ST_GAP) |-> (len != 3'd0 && idx < len))
    else $error("symbol index out of range");

  // The queue is only read from idle, and then the output path moves on
  assert property (@(posedge clk) disable iff (rst)
    q_rd |=> (state != ST_SYM || idx == 3'd0))
    else $error("character loaded mid-sequence");

endmodule
